@@ rtl/adsr_eop_pkg.sv @@
// Shared types and constants for the one-pole ADSR envelope block.
package adsr_eop_pkg;

  localparam int SAMPLE_W = 16;
  localparam int MCAND_W  = SAMPLE_W + 1;
  localparam int MLT_W    = SAMPLE_W;
  localparam int PROD_W   = MCAND_W + MLT_W;
  localparam int CNT_W    = $clog2(MLT_W);

  localparam logic [SAMPLE_W-1:0] ATTACK_DONE = 16'd32440;

  localparam logic [SAMPLE_W-1:0] ATTACK_POLE_RST  = 16'd65513;
  localparam logic [SAMPLE_W-1:0] DECAY_POLE_RST   = 16'd65522;
  localparam logic [SAMPLE_W-1:0] RELEASE_POLE_RST = 16'd65531;
  localparam logic [SAMPLE_W-1:0] SUSTAIN_RST      = 16'd16384;

  typedef enum logic [1:0] {
    REG_ATTACK_POLE  = 2'd0,
    REG_DECAY_POLE   = 2'd1,
    REG_RELEASE_POLE = 2'd2,
    REG_SUSTAIN      = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_CLEAR   = 2'd0,
    MODE_ATTACK  = 2'd1,
    MODE_DECAY   = 2'd2,
    MODE_RELEASE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TMUL,
    ST_DIFF,
    ST_DMUL,
    ST_UPD,
    ST_OUT
  } state_t;

endpackage

@@ rtl/adsr_eop_mul.sv @@
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module adsr_eop_mul (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [adsr_eop_pkg::MCAND_W-1:0] mcand,
  input  logic [adsr_eop_pkg::MLT_W-1:0]   mlt,
  output logic                             done,
  output logic [adsr_eop_pkg::PROD_W-1:0]  prod
);
  import adsr_eop_pkg::*;

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [MCAND_W-1:0] mc;
  logic [MCAND_W-1:0] hi;
  logic [MLT_W-1:0]   lo;
  logic [MCAND_W:0]   sum;

  // partial sum of the upper half plus the multiplicand when the low bit is set
  assign sum  = {1'b0, hi} + (lo[0] ? {1'b0, mc} : {(MCAND_W + 1){1'b0}});
  assign done = busy && (cnt == CNT_W'(MLT_W - 1));
  assign prod = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      if (done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mc <= mcand;
      hi <= '0;
      lo <= mlt;
    end else if (busy) begin
      hi <= sum[MCAND_W:1];
      lo <= {sum[0], lo[MLT_W-1:1]};
    end
  end

endmodule

@@ rtl/adsr_envelope_one_pole_top.sv @@
// Top level: ADSR envelope generator on one one-pole filter, serial multiply.
// Clear mode skips the 16-step serial multiplies; attack runs only b * |d|, while
// decay and release run gate * sustain first. A new word is taken only in idle.
// A finished word waits in the output register while the next word is taken.
// Reset (rst, synchronous, active high): clear mode, gate and filter memory zero,
// configuration registers to their defaults, no output word pending.
module adsr_envelope_one_pole_top (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] gate,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] envelope,
  output logic [1:0]  phase
);
  import adsr_eop_pkg::*;

  // configuration registers
  logic [SAMPLE_W-1:0] attack_pole;
  logic [SAMPLE_W-1:0] decay_pole;
  logic [SAMPLE_W-1:0] release_pole;
  logic [SAMPLE_W-1:0] sustain_level;

  // envelope state
  mode_t               mode;
  logic [SAMPLE_W-1:0] last_gate;
  logic [SAMPLE_W-1:0] filter_out;

  // per-word working registers
  logic [SAMPLE_W-1:0] gate_r;
  logic                neg;
  logic [SAMPLE_W-1:0] env_r;

  state_t state, state_next;

  logic      accept;
  logic      out_load;
  mode_t     mode_next;
  logic      mul_start;
  logic      mul_done;
  logic [MCAND_W-1:0] mcand;
  logic [MLT_W-1:0]   mlt;
  logic [PROD_W-1:0]  prod;

  // filter arithmetic
  logic [SAMPLE_W-1:0] target;
  logic                ge;
  logic [SAMPLE_W-1:0] mag;
  logic [SAMPLE_W-1:0] pole;
  logic [MCAND_W-1:0]  coef_b;
  logic [MCAND_W-1:0]  step;
  logic [SAMPLE_W-1:0] filt_new;

  adsr_eop_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .mcand (mcand),
    .mlt   (mlt),
    .done  (mul_done),
    .prod  (prod)
  );

  // ---------------------------------------------------------------------------
  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      attack_pole   <= ATTACK_POLE_RST;
      decay_pole    <= DECAY_POLE_RST;
      release_pole  <= RELEASE_POLE_RST;
      sustain_level <= SUSTAIN_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_ATTACK_POLE:  attack_pole   <= cfg_data;
        REG_DECAY_POLE:   decay_pole    <= cfg_data;
        REG_RELEASE_POLE: release_pole  <= cfg_data;
        REG_SUSTAIN:      sustain_level <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // mode update on an incoming gate: rising edge starts attack except in
  // decay, any falling edge starts release
  always_comb begin
    mode_next = mode;
    if ((last_gate < gate) && (mode != MODE_DECAY)) begin
      mode_next = MODE_ATTACK;
    end else if (last_gate > gate) begin
      mode_next = MODE_RELEASE;
    end
  end

  // target: gate in attack, (gate * sustain) >> 15 saturated otherwise
  always_comb begin
    if (mode == MODE_ATTACK) begin
      target = gate_r;
    end else if (prod[PROD_W-1:SAMPLE_W+15] != '0) begin
      target = '1;
    end else begin
      target = prod[SAMPLE_W+14:15];
    end
  end

  assign ge  = target >= filter_out;
  assign mag = ge ? (target - filter_out) : (filter_out - target);

  always_comb begin
    case (mode)
      MODE_ATTACK: pole = attack_pole;
      MODE_DECAY:  pole = decay_pole;
      default:     pole = release_pole;
    endcase
  end

  assign coef_b = {1'b1, {SAMPLE_W{1'b0}}} - {1'b0, pole};

  // ceil(b * |d| / 2^16): upper half plus one if any low bit is set
  assign step     = prod[PROD_W-1:SAMPLE_W] + MCAND_W'(|prod[SAMPLE_W-1:0]);
  assign filt_new = neg ? (filter_out - step[SAMPLE_W-1:0])
                        : (filter_out + step[SAMPLE_W-1:0]);

  // multiplier operands: gate * sustain for the target, b * |d| for the step
  always_comb begin
    if (state == ST_IDLE) begin
      mcand = {1'b0, sustain_level};
      mlt   = gate;
    end else begin
      mcand = coef_b;
      mlt   = mag;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer: next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (mode_next)
            MODE_CLEAR:  state_next = ST_OUT;
            MODE_ATTACK: state_next = ST_DIFF;
            default:     state_next = ST_TMUL;
          endcase
        end
      end
      ST_TMUL: if (mul_done) state_next = ST_DIFF;
      ST_DIFF: state_next = ST_DMUL;
      ST_DMUL: if (mul_done) state_next = ST_UPD;
      ST_UPD:  state_next = ST_OUT;
      ST_OUT:  if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_stall  = 1'b1;
    mul_start = 1'b0;
    out_load  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall  = 1'b0;
        mul_start = in_valid && (mode_next != MODE_CLEAR) && (mode_next != MODE_ATTACK);
      end
      ST_DIFF: mul_start = 1'b1;
      ST_OUT:  out_load  = !out_valid || !out_stall;
      default: ;
    endcase
  end

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------------------
  // envelope state and per-word registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_CLEAR;
      last_gate  <= '0;
      filter_out <= '0;
    end else begin
      if (accept) begin
        mode      <= mode_next;
        last_gate <= gate;
      end
      if (state == ST_UPD) begin
        filter_out <= filt_new;
        if ((mode == MODE_ATTACK) && (filt_new > ATTACK_DONE)) begin
          mode <= MODE_DECAY;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      gate_r <= gate;
      env_r  <= '0;
    end
    if (state == ST_DIFF) begin
      neg <= !ge;
    end
    if (state == ST_UPD) begin
      env_r <= filt_new;
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      envelope <= env_r;
      phase    <= mode;
    end
  end

endmodule

@@ tb/tb_adsr_envelope_one_pole_top.sv @@
// Testbench for the one-pole ADSR envelope block: directed and random gates checked by a predictor.
module tb_adsr_envelope_one_pole_top;
  import adsr_eop_pkg::*;

  // Generous cycle budget for the whole run.
  localparam int CYCLE_LIMIT = 400000;
  // Extra wait after the drain, used as the settle time before register writes.
  localparam int SETTLE_CYCLES = 40;
  // Length of the one long receiver hold-off.
  localparam int HOLD_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] gate;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] envelope;
  logic [1:0]  phase;

  adsr_envelope_one_pole_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .gate      (gate),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .envelope  (envelope),
    .phase     (phase)
  );

  // Tracks the envelope state machine and holds the envelope words still due.
  class envelope_tracker;
    logic [15:0] att_pole;
    logic [15:0] dec_pole;
    logic [15:0] rel_pole;
    logic [15:0] sus_lvl;
    mode_t       mode;
    logic [15:0] prev_gate;
    logic [15:0] filt;
    logic [15:0] want_env[$];
    mode_t       want_phase[$];
    int          errs;
    int          shown;

    function new();
      att_pole  = ATTACK_POLE_RST;
      dec_pole  = DECAY_POLE_RST;
      rel_pole  = RELEASE_POLE_RST;
      sus_lvl   = SUSTAIN_RST;
      mode      = MODE_CLEAR;
      prev_gate = '0;
      filt      = '0;
      errs      = 0;
      shown     = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [15:0] v);
      case (idx)
        REG_ATTACK_POLE:  att_pole = v;
        REG_DECAY_POLE:   dec_pole = v;
        REG_RELEASE_POLE: rel_pole = v;
        default:          sus_lvl  = v;
      endcase
    endfunction

    function int outstanding();
      return want_env.size();
    endfunction

    // One filter update; the step is rounded up so the target is always reached.
    function logic [15:0] pole_step(logic [15:0] pole, logic [15:0] x);
      logic [16:0] b;
      logic [15:0] d;
      logic [33:0] mag;
      b   = 17'h10000 - 17'(pole);
      d   = (x >= filt) ? x - filt : filt - x;
      mag = (34'(b) * 34'(d) + 34'd65535) >> 16;
      if (x >= filt) filt = filt + mag[15:0];
      else filt = filt - mag[15:0];
      return filt;
    endfunction

    function void take_gate(logic [15:0] g);
      logic [31:0] prod;
      logic [16:0] scaled;
      logic [15:0] tgt;
      logic [15:0] env;
      // Rising gate restarts attack except in decay; any falling gate releases.
      if (prev_gate < g && mode != MODE_DECAY) mode = MODE_ATTACK;
      else if (prev_gate > g) mode = MODE_RELEASE;
      prev_gate = g;
      env = '0;
      case (mode)
        MODE_ATTACK: begin
          env = pole_step(att_pole, g);
          if (env > ATTACK_DONE) mode = MODE_DECAY;
        end
        MODE_DECAY, MODE_RELEASE: begin
          prod   = 32'(g) * 32'(sus_lvl);
          scaled = prod[31:15];
          tgt    = scaled[16] ? 16'hFFFF : scaled[15:0];
          env    = pole_step((mode == MODE_DECAY) ? dec_pole : rel_pole, tgt);
        end
        default: env = '0;
      endcase
      want_env.push_back(env);
      want_phase.push_back(mode);
    endfunction

    function void match_word(logic [15:0] env, logic [1:0] ph);
      logic [15:0] e;
      mode_t       p;
      if (want_env.size() == 0) begin
        errs++;
        if (shown < 10) begin
          shown++;
          $display("unexpected envelope word: envelope=%0d phase=%0d", env, ph);
        end
        return;
      end
      e = want_env.pop_front();
      p = want_phase.pop_front();
      if (env !== e || ph !== p) begin
        errs++;
        if (shown < 10) begin
          shown++;
          $display({"envelope word mismatch: expected envelope=%0d phase=%0d, ",
                    "got envelope=%0d phase=%0d"}, e, p, env, ph);
        end
      end
    endfunction
  endclass

  envelope_tracker trk;

  int cycles = 0;
  int gates_sent = 0;
  int burst_left = 0;
  bit gappy = 1'b1;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int stall_kind = 0;
  int stall_left = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Both channels are observed at the rising edge, where a word moves.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) trk.take_gate(gate);
      if (out_valid && !out_stall) trk.match_word(envelope, phase);
    end
  end

  // Receiver: stall pattern changes at random between none, light and heavy. A hold
  // request from the stimulus keeps stall high for the one long hold-off.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (stall_left == 0) begin
      stall_kind = $urandom_range(0, 2);
      stall_left = $urandom_range(40, 300);
    end else begin
      stall_left--;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_kind)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  // Offers one gate word and returns once it is taken. Words go out in bursts;
  // between bursts valid drops for a random gap unless gaps are switched off.
  task automatic send_gate(logic [15:0] g);
    int pause;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gappy) begin
        pause = $urandom_range(1, 15);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (pause - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    gate     <= g;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gates_sent++;
  endtask

  // Stops offering and waits until every envelope word due has come back.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (trk.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    trk.set_reg(idx, v);
  endtask

  task automatic load_regs(logic [15:0] att, logic [15:0] dec, logic [15:0] rel,
                           logic [15:0] sus);
    write_reg(REG_ATTACK_POLE, att);
    write_reg(REG_DECAY_POLE, dec);
    write_reg(REG_RELEASE_POLE, rel);
    write_reg(REG_SUSTAIN, sus);
  endtask

  // Mostly notes: a held level (with the odd jump, which also hits rises during
  // decay), then a release tail. The rest is noise and cut-short notes.
  task automatic play(int count);
    int          stop_at;
    int          len;
    int          kind;
    logic [15:0] lvl;
    logic [15:0] tail;
    logic [15:0] g;
    stop_at = gates_sent + count;
    while (gates_sent < stop_at) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        lvl = ($urandom_range(0, 1) != 0) ? 16'd32768 : 16'($urandom_range(12000, 32768));
        len = $urandom_range(3, 40);
        repeat (len) begin
          g = lvl;
          if ($urandom_range(0, 7) == 0) g = 16'($urandom_range(0, 32768));
          send_gate(g);
        end
        tail = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, lvl)) : 16'd0;
        len  = $urandom_range(1, 20);
        repeat (len) send_gate(tail);
      end else if (kind < 9) begin
        len = $urandom_range(1, 10);
        repeat (len) send_gate(16'($urandom_range(0, 32768)));
      end else begin
        lvl = 16'($urandom_range(1, 32768));
        len = $urandom_range(1, 3);
        repeat (len) send_gate(lvl);
        send_gate(16'($urandom_range(0, 32768)));
      end
    end
  endtask

  initial begin
    // Reset values: clear mode, then a full-scale note, bit patterns and a fall.
    logic [15:0] dir_default[8] = '{16'd0, 16'd0, 16'd32768, 16'd32768, 16'd21845,
                                    16'd10922, 16'd1, 16'd0};
    // Zero poles: instant steps. Attack into decay, a rise ignored in decay,
    // release, an attack that stays below the threshold, and full scale.
    logic [15:0] dir_fast[10] = '{16'd32767, 16'd32768, 16'd1, 16'd16384, 16'd20000,
                                  16'd20000, 16'd0, 16'd32768, 16'd32768, 16'd0};
    // Slowest poles with zero sustain: one LSB per tick.
    logic [15:0] dir_slow[5] = '{16'd32768, 16'd32768, 16'd16384, 16'd0, 16'd0};

    trk       = new();
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = REG_ATTACK_POLE;
    cfg_data  = '0;
    in_valid  = 1'b0;
    gate      = '0;
    out_stall = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_default[i]) send_gate(dir_default[i]);
    settle();
    load_regs(16'd0, 16'd0, 16'd0, 16'd32768);
    foreach (dir_fast[i]) send_gate(dir_fast[i]);
    settle();
    load_regs(16'd65535, 16'd65535, 16'd65535, 16'd0);
    foreach (dir_slow[i]) send_gate(dir_slow[i]);
    settle();

    // Quick attack; partway in the receiver holds off so the block backs up.
    load_regs(16'($urandom_range(0, 40000)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)), 16'($urandom_range(0, 32768)));
    play(40);
    hold_req = 1'b1;
    play(90);
    settle();

    load_regs(16'd0, 16'd65535, 16'd0, 16'd32768);
    play(130);
    settle();

    // Attack is slowest here; sustain zero pulls release to zero.
    load_regs(16'd65535, 16'd0, 16'd65535, 16'd0);
    play(100);
    settle();

    // Full-range registers, with a pause for a complete drain midway.
    load_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)), 16'($urandom_range(0, 32768)));
    play(60);
    settle();
    play(70);
    settle();

    // Back-to-back offers, no gaps from the sender.
    gappy = 1'b0;
    load_regs(16'($urandom_range(0, 20000)), 16'($urandom_range(40000, 65535)),
              16'($urandom_range(40000, 65535)), 16'($urandom_range(16384, 32768)));
    play(130);
    settle();

    if (trk.errs == 0 && trk.outstanding() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
